[hw/rtl/tfv_pkg.sv]
package tfv_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  localparam logic [2:0] KIND_INTEGER  = 3'd0;
  localparam logic [2:0] KIND_DECIMAL  = 3'd1;
  localparam logic [2:0] KIND_VARCHAR  = 3'd2;
  localparam logic [2:0] KIND_DATETIME = 3'd3;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] NULL_WORD [4] = '{8'h4E, 8'h55, 8'h4C, 8'h4C};
  localparam logic [2:0] NULL_FULL = 3'd4;
  localparam logic [2:0] NULL_FAIL = 3'd7;
  localparam logic [1:0] HYPHEN_SAT = 2'd2;

  typedef struct packed {
    logic       lead_minus;
    logic       point_seen;
    logic       digits_only;
    logic       number_bad;
    logic       stamp_bad;
    logic [1:0] hyphen_count;
    logic       colon_seen;
    logic [2:0] null_match;
  } tfv_flags_t;

  localparam tfv_flags_t FLAGS_CLEAR = '{
    lead_minus:   1'b0,
    point_seen:   1'b0,
    digits_only:  1'b1,
    number_bad:   1'b0,
    stamp_bad:    1'b0,
    hyphen_count: 2'd0,
    colon_seen:   1'b0,
    null_match:   3'd0
  };

endpackage

[hw/rtl/tfv_in_if.sv]
interface tfv_in_if #(
  parameter int LENGTH_BITS = tfv_pkg::LENGTH_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             char_code;
  logic                   first_char;
  logic                   last_char;
  logic                   empty_field;
  logic [2:0]             column_kind;
  logic [LENGTH_BITS-1:0] length_limit;

  modport source (
    output valid, char_code, first_char, last_char, empty_field, column_kind, length_limit,
    input  ready
  );
  modport sink (
    input  valid, char_code, first_char, last_char, empty_field, column_kind, length_limit,
    output ready
  );
endinterface

[hw/rtl/tfv_out_if.sv]
interface tfv_out_if;
  logic valid;
  logic ready;
  logic field_valid;

  modport source (
    output valid, field_valid,
    input  ready
  );
  modport sink (
    input  valid, field_valid,
    output ready
  );
endinterface

[hw/rtl/tfv_step.sv]
module tfv_step #(
  parameter int LENGTH_BITS = tfv_pkg::LENGTH_BITS_DEF
) (
  input  logic [LENGTH_BITS:0]   count_i,
  input  tfv_pkg::tfv_flags_t    flags_i,
  input  logic [7:0]             char_code,
  input  logic                   first_char,
  input  logic                   last_char,
  input  logic                   empty_field,
  input  logic [2:0]             column_kind,
  input  logic [LENGTH_BITS-1:0] length_limit,
  output logic [LENGTH_BITS:0]   count_o,
  output tfv_pkg::tfv_flags_t    flags_o,
  output logic                   done_o,
  output logic                   field_valid_o
);
  import tfv_pkg::*;

  localparam logic [LENGTH_BITS:0] COUNT_MAX = '1;

  logic [LENGTH_BITS:0] base_count;
  logic [LENGTH_BITS:0] take_count;
  tfv_flags_t           base_flags;
  tfv_flags_t           take_flags;
  logic                 digit;
  logic                 lone_minus;
  logic                 kind_ok;

  always_comb begin
    base_count = first_char ? '0 : count_i;
    base_flags = first_char ? FLAGS_CLEAR : flags_i;
    digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    take_flags = base_flags;

    if (base_flags.null_match != NULL_FAIL) begin
      if ((base_count < (LENGTH_BITS+1)'(4))
          && ({{(LENGTH_BITS-2){1'b0}}, base_flags.null_match} == base_count)
          && (char_code == NULL_WORD[base_count[1:0]])) begin
        take_flags.null_match = base_flags.null_match + 3'd1;
      end else begin
        take_flags.null_match = NULL_FAIL;
      end
    end

    if ((base_count == '0) && (char_code == CH_MINUS)) begin
      take_flags.lead_minus = 1'b1;
    end else if (char_code == CH_DOT) begin
      if (base_flags.point_seen) begin
        take_flags.number_bad = 1'b1;
      end
      take_flags.point_seen = 1'b1;
    end else if (!digit) begin
      take_flags.number_bad = 1'b1;
    end

    if (!digit) begin
      take_flags.digits_only = 1'b0;
    end
    if (char_code == CH_MINUS) begin
      if (base_flags.hyphen_count < HYPHEN_SAT) begin
        take_flags.hyphen_count = base_flags.hyphen_count + 2'd1;
      end
    end else if (char_code == CH_COLON) begin
      take_flags.colon_seen = 1'b1;
    end else if (!digit && (char_code != CH_SPACE) && (char_code != CH_T)
                 && (char_code != CH_Z) && (char_code != CH_DOT)) begin
      take_flags.stamp_bad = 1'b1;
    end

    take_count = (base_count == COUNT_MAX) ? base_count
                                           : base_count + (LENGTH_BITS+1)'(1);

    lone_minus = take_flags.lead_minus && (take_count == (LENGTH_BITS+1)'(1));
    case (column_kind)
      KIND_INTEGER:  kind_ok = !take_flags.number_bad && !take_flags.point_seen
                               && !lone_minus;
      KIND_DECIMAL:  kind_ok = !take_flags.number_bad && !lone_minus;
      KIND_VARCHAR:  kind_ok = (length_limit == '0)
                               || (take_count <= {1'b0, length_limit});
      KIND_DATETIME: kind_ok = take_flags.digits_only
                               || (!take_flags.stamp_bad
                                   && ((take_flags.hyphen_count >= HYPHEN_SAT)
                                       || take_flags.colon_seen));
      default:       kind_ok = 1'b1;
    endcase

    done_o = empty_field || last_char;
    field_valid_o = empty_field || (take_flags.null_match == NULL_FULL) || kind_ok;
    count_o = done_o ? '0 : take_count;
    flags_o = done_o ? FLAGS_CLEAR : take_flags;
  end

endmodule

[hw/rtl/typed_field_validator.sv]
// The result appears in the output register in the cycle after the request
// that carries the last character (or the empty-field mark) is accepted.
// Throughput: one character request per cycle while input ready is high; the
// running field state and the result register update together on the same edge.
// Input ready is high while the result register is empty or being taken.
// Reset (rst_n low, synchronous) clears the field state and drops any pending result.
module typed_field_validator #(
  parameter int LENGTH_BITS = tfv_pkg::LENGTH_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  tfv_in_if.sink   in_ch,
  tfv_out_if.source out_ch
);
  import tfv_pkg::*;

  logic [LENGTH_BITS:0] count_r;
  logic [LENGTH_BITS:0] count_nxt;
  tfv_flags_t           flags_r;
  tfv_flags_t           flags_nxt;
  logic                 out_valid_r;
  logic                 out_field_valid_r;
  logic                 done;
  logic                 verdict;
  logic                 in_acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.field_valid = out_field_valid_r;

  tfv_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .count_i      (count_r),
    .flags_i      (flags_r),
    .char_code    (in_ch.char_code),
    .first_char   (in_ch.first_char),
    .last_char    (in_ch.last_char),
    .empty_field  (in_ch.empty_field),
    .column_kind  (in_ch.column_kind),
    .length_limit (in_ch.length_limit),
    .count_o      (count_nxt),
    .flags_o      (flags_nxt),
    .done_o       (done),
    .field_valid_o(verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flags_r <= FLAGS_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r <= count_nxt;
        flags_r <= flags_nxt;
      end
      if (in_acc && done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && done) begin
      out_field_valid_r <= verdict;
    end
  end

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && done) |=> out_valid_r)
    else $error("Finished field did not produce a result.");

  a_empty_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.empty_field) |=> out_field_valid_r)
    else $error("Empty field was not reported as valid.");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !done && out_ch.ready) |=> !out_valid_r)
    else $error("Result appeared for a request that does not end a field.");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && done) |=> ((count_r == '0) && (flags_r == FLAGS_CLEAR)))
    else $error("Field state not cleared after the end of a field.");

endmodule
